// ===== sv/sia_pkg.sv =====
// Package for the section index allocator: sizes, codes, index entry layout,
// controller state and command/status structs. No dependencies.
package sia_pkg;

  localparam int MAX_SECTIONS = 64;
  localparam int CNT_W  = $clog2(MAX_SECTIONS + 1);
  localparam int ADDR_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  localparam logic [15:0] HDR_BYTES = 16'd2;
  localparam logic [15:0] REC_BYTES = 16'd8;

  localparam logic [3:0]  PAGE_LOG2_RESET = 4'd6;
  localparam logic [15:0] TOTAL_PAGES_RESET = 16'd256;

  localparam logic CFG_PAGE_LOG2   = 1'b0;
  localparam logic CFG_TOTAL_PAGES = 1'b1;

  typedef enum logic [1:0] {
    ACT_GET  = 2'd0,
    ACT_READ = 2'd1,
    ACT_SET  = 2'd2,
    ACT_DEL  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_ALLOC    = 3'd1,
    ST_VER_BAD  = 3'd2,
    ST_SIZE_BAD = 3'd3,
    ST_NO_SPACE = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] start;
    logic [15:0] pages;
    logic [15:0] version;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_SCAN_EV,
    S_PASS,
    S_PLACE,
    S_PLACE_EV,
    S_ALLOC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic scan_ev;
    logic scan_end;
    logic pass_start;
    logic place_ev;
    logic alloc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic reserved;
    logic is_get;
    logic k_end;
    logic stop;
    logic place_bad;
    logic pass_go;
    logic pass_low;
    logic place_fail;
    logic out_free;
  } sts_t;

  // bytes rounded up to whole pages
  function automatic logic [15:0] pages_for(input logic [15:0] bytes, input logic [3:0] lg);
    logic [15:0] mask;
    mask = ~(16'hFFFF << lg);
    return (bytes >> lg) + {15'd0, |(bytes & mask)};
  endfunction

endpackage

// ===== sv/sia_ifs.sv =====
// Request and response channel interfaces for the section index allocator.
// Depends on sia_pkg.
interface sia_req_if import sia_pkg::*; ();
  logic        valid;
  logic        ready;
  action_t     action;
  logic [15:0] sec_id;
  logic [15:0] sec_version;
  logic [15:0] sec_size;
  modport source (output valid, action, sec_id, sec_version, sec_size,
                  input ready);
  modport sink (input valid, action, sec_id, sec_version, sec_size,
                output ready);
endinterface

interface sia_rsp_if import sia_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [15:0] start_page;
  logic [15:0] version_out;
  modport source (output valid, status, start_page, version_out, input ready);
  modport sink (input valid, status, start_page, version_out, output ready);
endinterface

// ===== sv/section_index_allocator_core.sv =====
// Section index allocator, top level. One request at a time; set and delete scan
// all N index entries (N = index entries), a get or read stops at a matching id,
// a get of id 0 skips the scan, and an allocating get scans and then runs
// placement passes over the entries. The next request is taken in the cycle the
// result turns valid. The index scan reads one entry at a time (registered read).
// Reset empties the index and loads the config defaults; no clearing pass.
module section_index_allocator_core import sia_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sia_req_if.sink     req,
  sia_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;

  sia_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sia_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_action   (req.action),
    .in_id       (req.sec_id),
    .in_version  (req.sec_version),
    .in_size     (req.sec_size),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_start   (rsp.start_page),
    .out_version (rsp.version_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );
endmodule

// ===== sv/sia_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/sia_datapath.sv =====
// Datapath: request/result registers, config registers, entry count, scan
// and placement arithmetic, index RAM. Depends on sia_pkg and sia_ram.
module sia_datapath import sia_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  action_t     in_action,
  input  logic [15:0] in_id,
  input  logic [15:0] in_version,
  input  logic [15:0] in_size,
  output logic        out_valid,
  input  logic        out_ready,
  output status_t     out_status,
  output logic [15:0] out_start,
  output logic [15:0] out_version,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [3:0]       page_log2;
  logic [15:0]      total_pages;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] w;
  action_t          req_action;
  logic [15:0]      req_id;
  logic [15:0]      req_version;
  logic [15:0]      req_size;
  logic [15:0]      pg;
  logic [15:0]      at;
  logic             moved;
  status_t          res_status;
  logic [15:0]      res_start;
  logic [15:0]      res_version;

  entry_t            rd_entry;
  logic [63:0]       rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  entry_t            wentry;
  logic              match;
  logic [15:0]       min_page;
  logic [16:0]       ent_end;
  logic [16:0]       at_end;
  logic              overlap;

  sia_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_SECTIONS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (k[ADDR_W-1:0]),
    .rdata (rdata)
  );

  assign rd_entry = entry_t'(rdata);
  assign match    = (rd_entry.id == req_id);
  assign min_page = pages_for(HDR_BYTES + 16'((count + CNT_W'(2))) * REC_BYTES, page_log2);
  assign ent_end  = {1'b0, rd_entry.start} + {1'b0, rd_entry.pages};
  assign at_end   = {1'b0, at} + {1'b0, pg};
  assign overlap  = ({1'b0, at} < ent_end) && ({1'b0, rd_entry.start} < at_end);

  always_comb begin
    sts.reserved   = (req_action == ACT_GET) && (req_id == 16'd0);
    sts.is_get     = (req_action == ACT_GET);
    sts.k_end      = (k == count);
    sts.stop       = match && ((req_action == ACT_GET) || (req_action == ACT_READ));
    sts.place_bad  = (count >= CNT_W'(MAX_SECTIONS)) || (pg > total_pages);
    sts.pass_go    = moved && (at >= min_page);
    sts.pass_low   = (at < min_page);
    sts.place_fail = overlap && (rd_entry.start < pg);
    sts.out_free   = !out_valid || out_ready;
  end

  // RAM write: version update, delete compaction, new entry
  always_comb begin
    we     = 1'b0;
    waddr  = k[ADDR_W-1:0];
    wentry = rd_entry;
    if (cmd.scan_ev && (req_action == ACT_SET) && match) begin
      we = 1'b1;
      wentry.version = req_version;
    end else if (cmd.scan_ev && (req_action == ACT_DEL) && !match) begin
      we    = 1'b1;
      waddr = w[ADDR_W-1:0];
    end else if (cmd.alloc) begin
      we     = 1'b1;
      waddr  = count[ADDR_W-1:0];
      wentry = '{id: req_id, start: at, pages: pg, version: req_version};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_log2   <= PAGE_LOG2_RESET;
      total_pages <= TOTAL_PAGES_RESET;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PAGE_LOG2:   page_log2 <= cfg_data[3:0];
          CFG_TOTAL_PAGES: total_pages <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.scan_end && (req_action == ACT_DEL)) begin
        count <= w;
      end
      if (cmd.alloc) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action  <= in_action;
      req_id      <= in_id;
      req_version <= in_version;
      req_size    <= in_size;
    end
    if (cmd.prep) begin
      pg          <= pages_for(req_size, page_log2);
      k           <= '0;
      w           <= '0;
      moved       <= 1'b1;
      res_status  <= sts.reserved ? ST_NO_SPACE : ST_DONE;
      res_start   <= 16'd0;
      res_version <= 16'd0;
    end
    if (cmd.scan_ev) begin
      k <= k + CNT_W'(1);
      if (match) begin
        unique case (req_action)
          ACT_GET: begin
            if (rd_entry.version != req_version) begin
              res_status <= ST_VER_BAD;
            end else if (rd_entry.pages != pg) begin
              res_status <= ST_SIZE_BAD;
            end else begin
              res_status <= ST_FOUND;
              res_start  <= rd_entry.start;
            end
          end
          ACT_READ: res_version <= rd_entry.version;
          default: ;
        endcase
      end else if (req_action == ACT_DEL) begin
        w <= w + CNT_W'(1);
      end
    end
    if (cmd.scan_end && (req_action == ACT_GET)) begin
      at <= total_pages - pg;
      if (sts.place_bad) begin
        res_status <= ST_NO_SPACE;
      end
    end
    if (cmd.pass_start) begin
      if (sts.pass_go) begin
        moved <= 1'b0;
        k     <= '0;
      end else if (sts.pass_low) begin
        res_status <= ST_NO_SPACE;
      end
    end
    if (cmd.place_ev) begin
      k <= k + CNT_W'(1);
      if (overlap) begin
        moved <= 1'b1;
        if (sts.place_fail) begin
          res_status <= ST_NO_SPACE;
        end else begin
          at <= rd_entry.start - pg;
        end
      end
    end
    if (cmd.alloc) begin
      res_status <= ST_ALLOC;
      res_start  <= at;
    end
    if (cmd.finish) begin
      out_status  <= res_status;
      out_start   <= res_start;
      out_version <= res_version;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_SECTIONS)) else $error("entry count above capacity");
  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_ev |-> w <= k) else $error("compaction write ahead of read");
  a_alloc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> count < CNT_W'(MAX_SECTIONS)) else $error("allocation into full index");
endmodule

// ===== sv/sia_ctrl.sv =====
// Controller state machine: sequences the index scan, placement passes and
// result hand-off. Depends on sia_pkg.
module sia_ctrl import sia_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_PREP;
      S_PREP:    state_next = sts.reserved ? S_DONE : S_SCAN;
      S_SCAN: begin
        if (sts.k_end) begin
          state_next = (sts.is_get && !sts.place_bad) ? S_PASS : S_DONE;
        end else begin
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: state_next = sts.stop ? S_DONE : S_SCAN;
      S_PASS: begin
        if (sts.pass_go) state_next = S_PLACE;
        else if (sts.pass_low) state_next = S_DONE;
        else state_next = S_ALLOC;
      end
      S_PLACE:    state_next = sts.k_end ? S_PASS : S_PLACE_EV;
      S_PLACE_EV: state_next = sts.place_fail ? S_DONE : S_PLACE;
      S_ALLOC:    state_next = S_DONE;
      S_DONE:     if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_PREP:     cmd.prep = 1'b1;
      S_SCAN:     cmd.scan_end = sts.k_end;
      S_SCAN_EV:  cmd.scan_ev = 1'b1;
      S_PASS:     cmd.pass_start = 1'b1;
      S_PLACE:    ;
      S_PLACE_EV: cmd.place_ev = 1'b1;
      S_ALLOC:    cmd.alloc = 1'b1;
      S_DONE:     cmd.finish = sts.out_free;
      default:    ;
    endcase
  end
endmodule
